// ===== src/lkvc_pkg.sv =====
package lkvc_pkg;

  // Number of cells in the chain
  localparam int unsigned ENTRIES = 16;

  // Field widths
  localparam int unsigned KEY_W = 32;
  localparam int unsigned VAL_W = 32;
  localparam int unsigned CAP_W = 5;

  // Derived widths
  localparam int unsigned IDX_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int unsigned CNT_W = $clog2(ENTRIES + 1);
  localparam int unsigned CMP_W = (CNT_W > CAP_W) ? CNT_W : CAP_W;

  // Capacity register after reset
  localparam logic [CAP_W-1:0] CAP_RESET = CAP_W'(16);

  // Operation codes
  localparam logic OP_GET = 1'b0;
  localparam logic OP_SET = 1'b1;

  // One stored entry as it moves along the chain
  typedef struct packed {
    logic             valid;
    logic [KEY_W-1:0] key;
    logic [VAL_W-1:0] value;
  } entry_t;

  // Per-cell load controls
  typedef struct packed {
    logic take_new;
    logic take_prev;
  } cell_ctrl_t;

endpackage

// ===== src/lkvc_cell.sv =====
module lkvc_cell (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  lkvc_pkg::cell_ctrl_t       ctrl_i,
  input  lkvc_pkg::entry_t           prev_i,
  input  lkvc_pkg::entry_t           new_i,
  input  logic [lkvc_pkg::KEY_W-1:0] lookup_key_i,
  output lkvc_pkg::entry_t           entry_o,
  output logic                       match_o
);

  logic                       valid_q, valid_d;
  logic [lkvc_pkg::KEY_W-1:0] key_q, key_d;
  logic [lkvc_pkg::VAL_W-1:0] value_q, value_d;

  // Pick the next entry: fresh entry, neighbor's entry, or hold
  always_comb begin
    priority if (ctrl_i.take_new) begin
      valid_d = new_i.valid;
      key_d   = new_i.key;
      value_d = new_i.value;
    end else if (ctrl_i.take_prev) begin
      valid_d = prev_i.valid;
      key_d   = prev_i.key;
      value_d = prev_i.value;
    end else begin
      valid_d = valid_q;
      key_d   = key_q;
      value_d = value_q;
    end
  end

  // Hold the valid mark
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  // Hold key and value
  always_ff @(posedge clk_i) begin
    key_q   <= key_d;
    value_q <= value_d;
  end

  // Compare the looked-up key against this entry
  assign match_o = valid_q && (key_q == lookup_key_i);

  assign entry_o.valid = valid_q;
  assign entry_o.key   = key_q;
  assign entry_o.value = value_q;

endmodule

// ===== src/lru_key_value_cache.sv =====
// Fully associative key-value cache with least-recently-used replacement,
// built as a chain of ENTRIES cells ordered by recency: cell 0 holds the most
// recent entry, and valid entries fill the chain from cell 0 up. Every item
// (tuser = operation, 0 get / 1 set) compares its key against all cells in
// parallel; a hit moves the found entry to cell 0 while the cells in front
// of it step one place down, and a set that misses inserts at cell 0 and
// pushes the chain down to the first free cell or, once capacity_in_use
// entries are held, over the least recent one. One item is taken every clock
// cycle; the result waits in an output register, and the input stalls only
// while that register is full and not taken. The key compare plus the
// first-match search across the cells sets the cycle. capacity_in_use is 0
// treated as 1 and above ENTRIES as ENTRIES; lowering it drops nothing at
// once. Valid marks clear at reset, so no clearing pass is needed.
module lru_key_value_cache (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  // Configuration: capacity_in_use
  input  logic                          cfg_we_i,
  input  logic [lkvc_pkg::CAP_W-1:0]    cfg_wdata_i,
  // Input items
  input  logic                          s_axis_tvalid,
  output logic                          s_axis_tready,
  input  logic [63:0]                   s_axis_tdata,  // [31:0] key, [63:32] write_value
  input  logic                          s_axis_tuser,  // [0] operation
  // Result items
  output logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  output logic [31:0]                   m_axis_tdata,  // [31:0] read_value
  output logic                          m_axis_tuser   // [0] hit
);

  localparam int unsigned N = lkvc_pkg::ENTRIES;

  logic                          in_acc;
  logic                          op;
  logic [lkvc_pkg::KEY_W-1:0]    key;
  logic [lkvc_pkg::VAL_W-1:0]    wval;

  logic [lkvc_pkg::CAP_W-1:0]    cap_q;
  logic [lkvc_pkg::CNT_W-1:0]    occ_q, occ_d;
  logic                          out_valid_q;
  logic                          out_hit_q;
  logic [lkvc_pkg::VAL_W-1:0]    out_value_q;

  lkvc_pkg::entry_t              cell_entry [N];
  lkvc_pkg::cell_ctrl_t          cell_ctrl  [N];
  lkvc_pkg::entry_t              new_entry;
  logic [N-1:0]                  match;
  logic [N-1:0]                  prefix;
  logic [N-1:0]                  first;
  logic [N-1:0]                  valid_vec;
  logic                          hit;
  logic [lkvc_pkg::VAL_W-1:0]    found_value;

  logic [lkvc_pkg::CMP_W-1:0]    eff_cap;
  logic [lkvc_pkg::CMP_W-1:0]    occ_ext;
  logic                          full;
  logic [lkvc_pkg::CNT_W-1:0]    target_cnt;
  logic [lkvc_pkg::IDX_W-1:0]    target;
  logic                          insert;

  assign op   = s_axis_tuser;
  assign key  = s_axis_tdata[31:0];
  assign wval = s_axis_tdata[63:32];

  assign s_axis_tready = !out_valid_q || m_axis_tready;
  assign in_acc        = s_axis_tvalid && s_axis_tready;

  // Chain of cells
  for (genvar i = 0; i < N; i++) begin : g_cell
    lkvc_pkg::entry_t prev;
    if (i == 0) begin : g_head
      assign prev = new_entry;
    end else begin : g_body
      assign prev = cell_entry[i-1];
    end
    lkvc_cell u_cell (
      .clk_i        (clk_i),
      .rst_ni       (rst_ni),
      .ctrl_i       (cell_ctrl[i]),
      .prev_i       (prev),
      .new_i        (new_entry),
      .lookup_key_i (key),
      .entry_o      (cell_entry[i]),
      .match_o      (match[i])
    );
    assign valid_vec[i] = cell_entry[i].valid;
  end

  // Find the first matching cell and its value
  always_comb begin
    prefix[0]   = 1'b0;
    for (int i = 1; i < N; i++) begin
      prefix[i] = prefix[i-1] | match[i-1];
    end
    first       = match & ~prefix;
    found_value = '0;
    for (int i = 0; i < N; i++) begin
      found_value = found_value | ({lkvc_pkg::VAL_W{first[i]}} & cell_entry[i].value);
    end
  end

  assign hit = |match;

  // Choose the insert position from occupancy and capacity
  always_comb begin
    occ_ext = lkvc_pkg::CMP_W'(occ_q);
    if (cap_q == '0) begin
      eff_cap = lkvc_pkg::CMP_W'(1);
    end else if (lkvc_pkg::CMP_W'(cap_q) > lkvc_pkg::CMP_W'(N)) begin
      eff_cap = lkvc_pkg::CMP_W'(N);
    end else begin
      eff_cap = lkvc_pkg::CMP_W'(cap_q);
    end
    full       = (occ_ext >= eff_cap) && (occ_q != '0);
    target_cnt = full ? (occ_q - lkvc_pkg::CNT_W'(1)) : occ_q;
    if (target_cnt >= lkvc_pkg::CNT_W'(N - 1)) begin
      target = lkvc_pkg::IDX_W'(N - 1);
    end else begin
      target = target_cnt[lkvc_pkg::IDX_W-1:0];
    end
  end

  assign insert = in_acc && !hit && (op == lkvc_pkg::OP_SET);

  // Entry that lands in cell 0
  assign new_entry.valid = 1'b1;
  assign new_entry.key   = key;
  assign new_entry.value = (op == lkvc_pkg::OP_SET) ? wval : found_value;

  // Drive cell loads: shift the cells in front of the hit or insert point
  always_comb begin
    for (int i = 0; i < N; i++) begin
      cell_ctrl[i].take_new  = 1'b0;
      cell_ctrl[i].take_prev = 1'b0;
      if (i == 0) begin
        cell_ctrl[i].take_new = in_acc && (hit || (op == lkvc_pkg::OP_SET));
      end else begin
        cell_ctrl[i].take_prev = (in_acc && hit && !prefix[i])
                              || (insert && (lkvc_pkg::IDX_W'(i) <= target));
      end
    end
  end

  // Advance occupancy on an insert that takes a free cell
  assign occ_d = (insert && !full) ? (occ_q + lkvc_pkg::CNT_W'(1)) : occ_q;

  // Hold configuration, occupancy and the output register's valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cap_q       <= lkvc_pkg::CAP_RESET;
      occ_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        cap_q <= cfg_wdata_i;
      end
      occ_q <= occ_d;
      if (in_acc) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Capture the result
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      out_hit_q   <= hit;
      out_value_q <= (hit && (op == lkvc_pkg::OP_GET)) ? found_value : '0;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tuser  = out_hit_q;
  assign m_axis_tdata  = out_value_q;

`ifndef SYNTH
  a_occ_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    occ_q <= lkvc_pkg::CNT_W'(N))
    else $error("occupancy beyond entry count");

  a_valid_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $countones(valid_vec) == int'(occ_q))
    else $error("valid cells disagree with occupancy");

  a_valid_packed: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (valid_vec & (valid_vec + N'(1))) == '0)
    else $error("valid cells not packed from the head");

  a_key_unique: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot0(match))
    else $error("key held in more than one cell");

  a_head_after_set: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_acc && (op == lkvc_pkg::OP_SET)) |=> (valid_vec[0] && (cell_entry[0].key == $past(key))))
    else $error("set item not placed at the head");
`endif

endmodule
